// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] block_type;
   typedef logic [7:0][31:0] hash_type;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS = 64;
   localparam int unsigned SLOT_BITS = $clog2(BLOCK_WORDS);
   localparam int unsigned ROUND_BITS = $clog2(ROUNDS);

   // Last word slot that still leaves room for the 64-bit length in the block.
   localparam logic [SLOT_BITS-1:0] LAST_MARK_SLOT = SLOT_BITS'(BLOCK_WORDS - 3);
   localparam logic [SLOT_BITS-1:0] LEN_HI_SLOT = SLOT_BITS'(BLOCK_WORDS - 2);
   localparam logic [SLOT_BITS-1:0] LEN_LO_SLOT = SLOT_BITS'(BLOCK_WORDS - 1);

   localparam word_type PAD_MARK_WORD = 32'h8000_0000;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   // Control from the message sequencer to the compression unit.
   typedef struct packed {
      logic start;
      logic reload;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type round_const(logic [ROUND_BITS-1:0] t);
      word_type k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/sha256_if.sv =====
interface sha256_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        last_word;

   modport source (output valid, output message_word, output valid_bytes,
                   output last_word, input ready);
   modport sink (input valid, input message_word, input valid_bytes,
                 input last_word, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part_0;
   logic [63:0] digest_part_1;
   logic [63:0] digest_part_2;
   logic [63:0] digest_part_3;

   modport source (output valid, output digest_part_0, output digest_part_1,
                   output digest_part_2, output digest_part_3, input ready);
   modport sink (input valid, input digest_part_0, input digest_part_1,
                 input digest_part_2, input digest_part_3, output ready);
endinterface

// ===== sv/sha256_core.sv =====
module sha256_core (
   input  logic                     clock,
   input  logic                     reset,
   input  sha256_pkg::core_ctl_type ctl,
   input  sha256_pkg::block_type    block,
   output sha256_pkg::core_stat_type stat,
   output sha256_pkg::hash_type     hash
);
   import sha256_pkg::*;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   hash_type  hash_ff, hash_in;
   hash_type  vars_ff, vars_in;
   block_type window_ff, window_in;

   word_type s0, s1, ch, mj, t1, t2, g0, g1, w_next;
   word_type va, vb, vc, vd, ve, vf, vg, vh;

   assign va = vars_ff[0];
   assign vb = vars_ff[1];
   assign vc = vars_ff[2];
   assign vd = vars_ff[3];
   assign ve = vars_ff[4];
   assign vf = vars_ff[5];
   assign vg = vars_ff[6];
   assign vh = vars_ff[7];

   // One round of the compression function, with the schedule word for
   // sixteen rounds ahead computed alongside.
   always_comb begin
      s1 = rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25);
      ch = (ve & vf) ^ (~ve & vg);
      t1 = vh + s1 + ch + round_const(round_ff) + window_ff[0];
      s0 = rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22);
      mj = (va & vb) ^ (va & vc) ^ (vb & vc);
      t2 = s0 + mj;
      g0 = rotr(window_ff[1], 7) ^ rotr(window_ff[1], 18) ^ (window_ff[1] >> 3);
      g1 = rotr(window_ff[14], 17) ^ rotr(window_ff[14], 19) ^ (window_ff[14] >> 10);
      w_next = window_ff[0] + g0 + window_ff[9] + g1;
   end

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      hash_in   = hash_ff;
      vars_in   = vars_ff;
      window_in = window_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (ctl.reload) begin
               hash_in = INIT_HASH;
            end
            if (ctl.start) begin
               vars_in   = hash_ff;
               window_in = block;
               round_in  = '0;
               state_in  = CORE_ROUND;
            end
         end
         CORE_ROUND: begin
            vars_in = {vg, vf, ve, vd + t1, vc, vb, va, t1 + t2};
            window_in = {w_next, window_ff[15:1]};
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_BITS'(ROUNDS - 1)) begin
               state_in = CORE_ADD;
            end
         end
         CORE_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            state_in = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= '0;
         hash_ff  <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff   <= vars_in;
      window_ff <= window_in;
   end

   assign stat.busy = (state_ff != CORE_IDLE);
   assign stat.done = (state_ff == CORE_ADD);
   assign hash = hash_ff;

endmodule

// ===== sv/sha256_message_digest.sv =====
// SHA-256 message digest engine. A message streams in on the request channel
// as big-endian 32-bit words, first byte in bits 31 to 24, each transaction
// carrying a count of valid leading bytes (values above four count as four)
// and a last-word flag. Only the last word of a message may be partial; a
// partial word without the last flag is taken and dropped without effect.
// Full words enter one per cycle while the sequencer is idle, into a 16-word
// block buffer. The compression unit loads the block on the same edge that
// takes its sixteenth word, and the request channel then stalls while the
// unit runs the SHA-256 rounds and then the final hash addition. On the
// last word the sequencer writes the padding one word per cycle, pausing
// while a block compresses, into the rest of the block (the 0x80 marker,
// zero fill, then the 64-bit bit length, which wraps modulo 2^64), which may
// take one extra block of padding and thus one extra compression. After the
// final compression, once the output register is free, the 256-bit digest
// moves into the output register as one response transaction split into
// four 64-bit big-endian parts, and the hash state reloads the initial
// values for the next message. The output register decouples the two sides:
// the next message is accepted while a digest waits to be taken.
module sha256_message_digest (
   input logic          clock,
   input logic          reset,
   sha256_req_if.sink   req_chan,
   sha256_rsp_if.source rsp_chan
);
   import sha256_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_HASH,
      ST_FLUSH
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [63:0] bits_ff, bits_in;
   logic pad_ff, pad_in;          // Padding of the current message is underway.
   logic mark_pend_ff, mark_pend_in;  // The 0x80 marker still needs a word.
   logic mark_ok_ff, mark_ok_in;  // The length fits in the current block.
   logic final_ff, final_in;      // The block in flight is the last one.
   logic rsp_valid_ff, rsp_valid_in;
   hash_type digest_ff;

   block_type block_ff;
   block_type core_block;
   logic wr_en;
   word_type wr_data;

   core_ctl_type  core_ctl;
   core_stat_type core_stat;
   hash_type      core_hash;

   logic accept;
   logic [2:0] byte_cnt;
   word_type last_data;
   logic load_digest;
   logic slot_full;

   sha256_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .block (core_block),
      .stat  (core_stat),
      .hash  (core_hash)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign byte_cnt = req_chan.valid_bytes[2] ? 3'd4 : req_chan.valid_bytes;
   assign slot_full = (slot_ff == LEN_LO_SLOT);

   // The unit loads its block on the edge that writes the last slot, so that
   // slot comes straight from the write data.
   always_comb begin
      core_block = block_ff;
      core_block[LEN_LO_SLOT] = wr_data;
   end

   // The last word keeps its valid bytes, takes the marker in the first
   // unused byte lane if there is one, and zeros the rest.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < byte_cnt) begin
            last_data[31-8*k -: 8] = req_chan.message_word[31-8*k -: 8];
         end else if (3'(k) == byte_cnt) begin
            last_data[31-8*k -: 8] = PAD_MARK_BYTE;
         end else begin
            last_data[31-8*k -: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      bits_in      = bits_ff;
      pad_in       = pad_ff;
      mark_pend_in = mark_pend_ff;
      mark_ok_in   = mark_ok_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_data      = req_chan.message_word;
      load_digest  = 1'b0;
      core_ctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_chan.last_word) begin
                  if (byte_cnt == 3'd4) begin
                     wr_en   = 1'b1;
                     bits_in = bits_ff + 64'd32;
                     slot_in = slot_ff + 1'b1;
                     if (slot_full) begin
                        core_ctl.start = 1'b1;
                        state_in = ST_HASH;
                     end
                  end
               end else begin
                  wr_en        = 1'b1;
                  wr_data      = last_data;
                  bits_in      = bits_ff + {58'd0, byte_cnt, 3'b000};
                  pad_in       = 1'b1;
                  final_in     = 1'b0;
                  mark_pend_in = (byte_cnt == 3'd4);
                  mark_ok_in   = (byte_cnt != 3'd4) && (slot_ff <= LAST_MARK_SLOT);
                  slot_in      = slot_ff + 1'b1;
                  if (slot_full) begin
                     core_ctl.start = 1'b1;
                     state_in = ST_HASH;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (mark_pend_ff) begin
               wr_data      = PAD_MARK_WORD;
               mark_pend_in = 1'b0;
               mark_ok_in   = (slot_ff <= LAST_MARK_SLOT);
            end else if (mark_ok_ff && slot_ff == LEN_HI_SLOT) begin
               wr_data = bits_ff[63:32];
            end else if (mark_ok_ff && slot_ff == LEN_LO_SLOT) begin
               wr_data  = bits_ff[31:0];
               final_in = 1'b1;
            end else begin
               wr_data = '0;
            end
            slot_in = slot_ff + 1'b1;
            if (slot_full) begin
               core_ctl.start = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (core_stat.done) begin
               if (final_ff) begin
                  state_in = ST_FLUSH;
               end else if (pad_ff) begin
                  // A fresh block after the marker always has room for the length.
                  if (!mark_pend_ff) begin
                     mark_ok_in = 1'b1;
                  end
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_digest     = 1'b1;
               rsp_valid_in    = 1'b1;
               core_ctl.reload = 1'b1;
               bits_in         = '0;
               pad_in          = 1'b0;
               final_in        = 1'b0;
               mark_ok_in      = 1'b0;
               mark_pend_in    = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         bits_ff      <= '0;
         pad_ff       <= 1'b0;
         mark_pend_ff <= 1'b0;
         mark_ok_ff   <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         bits_ff      <= bits_in;
         pad_ff       <= pad_in;
         mark_pend_ff <= mark_pend_in;
         mark_ok_ff   <= mark_ok_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Block buffer and digest register carry data only.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_ff[slot_ff] <= wr_data;
      end
      if (load_digest) begin
         digest_ff <= core_hash;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.digest_part_0 = {digest_ff[0], digest_ff[1]};
   assign rsp_chan.digest_part_1 = {digest_ff[2], digest_ff[3]};
   assign rsp_chan.digest_part_2 = {digest_ff[4], digest_ff[5]};
   assign rsp_chan.digest_part_3 = {digest_ff[6], digest_ff[7]};

endmodule
